[rtl/core/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared codes, constants and lane control type for the stereo equalizer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam logic [3:0] MODE_PASS = 4'd1;
    localparam logic [3:0] MODE_LOW  = 4'd2;
    localparam logic [3:0] MODE_BAND = 4'd4;
    localparam logic [3:0] MODE_HIGH = 4'd8;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam logic [1:0] BANK_LOW  = 2'd0;
    localparam logic [1:0] BANK_BAND = 2'd1;
    localparam logic [1:0] BANK_HIGH = 2'd2;

    localparam int BANKS      = 3;
    localparam int FRAC_SHIFT = 15;

    typedef struct packed {
        logic wr;
        logic issue;
        logic clear;
    } t_lane_ctl;

endpackage

[rtl/core/sfs_coef_mem.sv]
// ----------------------------------------------------------------------------
// sfs_coef_mem
// Coefficient store for all filter banks, one write and one registered read.
// ----------------------------------------------------------------------------
module sfs_coef_mem #(
    parameter int DEPTH     = 243,
    parameter int COEF_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic signed [COEF_BITS-1:0]  i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic signed [COEF_BITS-1:0]  o_rd_data
);

    logic signed [COEF_BITS-1:0] r_mem [DEPTH];
    logic signed [COEF_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/sfs_lane.sv]
// ----------------------------------------------------------------------------
// sfs_lane
// One channel: delay line memory, multiply-accumulate and output rounding.
// ----------------------------------------------------------------------------
module sfs_lane #(
    parameter int TAPS        = 81,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    parameter logic [SAMPLE_BITS-1:0] RESET_VAL = '0,
    parameter int PTR_W       = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfs_pkg::t_lane_ctl            i_ctl,
    input  logic [PTR_W-1:0]              i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_data,
    input  logic [PTR_W-1:0]              i_rd_addr,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    output logic                          o_busy,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    import sfs_pkg::*;

    localparam int P_W   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = P_W + ((TAPS > 1) ? $clog2(TAPS) : 0) + 1;
    localparam logic signed [ACC_W:0] ROUND_ADD = (ACC_W + 1)'(1) << FRAC_SHIFT;
    localparam logic signed [ACC_W:0] SAT_HI =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_BITS-1:0] r_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] r_rd_q;
    logic [TAPS-1:0]               r_vld;
    logic                          r_vld_q;
    logic                          r_rd_v;
    logic                          r_prod_v;
    logic signed [P_W-1:0]         r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [ACC_W:0]         w_rnd;
    logic signed [ACC_W:0]         w_shf;

    // unwritten entries read as the reset contents
    assign w_sample = r_vld_q ? r_rd_q : $signed(RESET_VAL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q  <= r_mem[i_rd_addr];
        r_vld_q <= r_vld[i_rd_addr];
        r_prod  <= w_sample * i_coef;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + $signed({{(ACC_W - P_W){r_prod[P_W-1]}}, r_prod});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_v   <= i_ctl.issue;
            r_prod_v <= r_rd_v;
        end
    end

    // round, floor shift, saturate
    always_comb begin
        w_rnd = $signed({r_acc[ACC_W-1], r_acc}) + ROUND_ADD;
        w_shf = w_rnd >>> FRAC_SHIFT;
        if (w_shf > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_shf < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_result = w_shf[SAMPLE_BITS-1:0];
        end
    end

    assign o_busy = r_rd_v | r_prod_v;

endmodule

[rtl/core/stereo_fir_filter_select.sv]
// ----------------------------------------------------------------------------
// stereo_fir_filter_select
// Stereo equalizer: pass, mute or one of three FIR filters per sample item.
// ----------------------------------------------------------------------------
// Every sample item writes both delay lines, then gives one result chosen by
// the mode register. In filter modes the left and right lanes run in parallel,
// each doing one multiply-accumulate per tap on a shared coefficient read
// port; a filtered item passes through the MAC and drain states to the done
// state, from which its result is loaded into the output register. Pass and
// mute items go from acceptance straight to the done state, while a coefficient
// write leaves the input free at once. One item is in work at a time; the input
// stalls until its result has moved into the output register, which holds it
// while the output side stalls. Coefficients must be written before a filter
// mode is selected.
module stereo_fir_filter_select #(
    parameter int TAPS        = 81,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    input  logic [1:0]                    i_coef_bank,
    input  logic [6:0]                    i_coef_index,
    input  logic signed [COEF_BITS-1:0]   i_coef_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    import sfs_pkg::*;

    localparam int PTR_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CDEPTH = BANKS * TAPS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam logic [CAW-1:0] BASE_LOW  = '0;
    localparam logic [CAW-1:0] BASE_BAND = CAW'(TAPS);
    localparam logic [CAW-1:0] BASE_HIGH = CAW'(2 * TAPS);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(TAPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [3:0]                    r_mode;
    logic [3:0]                    r_item_mode;
    logic [PTR_W-1:0]              r_ptr;
    logic [PTR_W-1:0]              r_pos;
    logic [PTR_W-1:0]              r_k;
    logic [CAW-1:0]                r_base;
    logic signed [SAMPLE_BITS-1:0] r_pass_l;
    logic signed [SAMPLE_BITS-1:0] r_pass_r;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    logic                          w_accept;
    logic                          w_sample;
    logic                          w_filter;
    logic [CAW-1:0]                w_mode_base;
    logic                          w_cwe;
    logic [CAW-1:0]                w_cw_base;
    logic                          w_bank_ok;
    logic [CAW-1:0]                w_cw_addr;
    logic                          w_load;
    t_lane_ctl                     w_ctl;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic                          w_busy_l;
    logic                          w_busy_r;
    logic signed [SAMPLE_BITS-1:0] w_res_l;
    logic signed [SAMPLE_BITS-1:0] w_res_r;
    logic signed [SAMPLE_BITS-1:0] w_sel_l;
    logic signed [SAMPLE_BITS-1:0] w_sel_r;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_sample   = w_accept && (i_func == FUNC_SAMPLE);

    always_comb begin
        w_filter    = 1'b1;
        w_mode_base = BASE_LOW;
        unique case (r_mode)
            MODE_LOW:  w_mode_base = BASE_LOW;
            MODE_BAND: w_mode_base = BASE_BAND;
            MODE_HIGH: w_mode_base = BASE_HIGH;
            default:   w_filter    = 1'b0;
        endcase
    end

    always_comb begin
        w_bank_ok = 1'b1;
        w_cw_base = BASE_LOW;
        unique case (i_coef_bank)
            BANK_LOW:  w_cw_base = BASE_LOW;
            BANK_BAND: w_cw_base = BASE_BAND;
            BANK_HIGH: w_cw_base = BASE_HIGH;
            default:   w_bank_ok = 1'b0;
        endcase
    end

    assign w_cwe = w_accept && (i_func == FUNC_COEF) && w_bank_ok
                   && (32'(i_coef_index) < TAPS);
    assign w_cw_addr = w_cw_base + CAW'(i_coef_index);

    assign w_ctl.wr    = w_sample;
    assign w_ctl.clear = w_sample;
    assign w_ctl.issue = (r_state == ST_MAC);

    sfs_coef_mem #(
        .DEPTH     (CDEPTH),
        .COEF_BITS (COEF_BITS)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_we      (w_cwe),
        .i_wr_addr (w_cw_addr),
        .i_wr_data (i_coef_value),
        .i_rd_addr (r_base + CAW'(r_k)),
        .o_rd_data (w_coef)
    );

    sfs_lane #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .RESET_VAL   ({SAMPLE_BITS{1'b1}}),
        .PTR_W       (PTR_W)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_ptr),
        .i_wr_data (i_left_in),
        .i_rd_addr (r_pos),
        .i_coef    (w_coef),
        .o_busy    (w_busy_l),
        .o_result  (w_res_l)
    );

    sfs_lane #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .RESET_VAL   ({SAMPLE_BITS{1'b0}}),
        .PTR_W       (PTR_W)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_ptr),
        .i_wr_data (i_right_in),
        .i_rd_addr (r_pos),
        .i_coef    (w_coef),
        .o_busy    (w_busy_r),
        .o_result  (w_res_r)
    );

    // merge: filter result, passed sample or mute
    always_comb begin
        unique case (r_item_mode) inside
            MODE_PASS: begin
                w_sel_l = r_pass_l;
                w_sel_r = r_pass_r;
            end
            MODE_LOW, MODE_BAND, MODE_HIGH: begin
                w_sel_l = w_res_l;
                w_sel_r = w_res_r;
            end
            default: begin
                w_sel_l = '0;
                w_sel_r = '0;
            end
        endcase
    end

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_sample) begin
                r_ptr <= (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_sample) begin
                        r_state <= w_filter ? ST_MAC : ST_DONE;
                    end
                end
                ST_MAC: begin
                    if (r_k == LAST) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!w_busy_l && !w_busy_r) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_item_mode <= r_mode;
            r_pass_l    <= i_left_in;
            r_pass_r    <= i_right_in;
            r_pos       <= r_ptr;
            r_k         <= '0;
            r_base      <= w_mode_base;
        end else if (r_state == ST_MAC) begin
            r_k   <= r_k + 1'b1;
            r_pos <= (r_pos == '0) ? LAST : r_pos - 1'b1;
        end
        if (w_load) begin
            r_left_out  <= w_sel_l;
            r_right_out <= w_sel_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < TAPS)
        else $error("history pointer out of range");

    a_coef_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_COEF) |=> (r_state == ST_IDLE))
        else $error("coefficient write started work");

    a_idle_lanes_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> (!w_busy_l && !w_busy_r))
        else $error("lane busy outside filter run");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not presented");

    a_mac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (32'(r_k) < TAPS && 32'(r_pos) < TAPS))
        else $error("tap counter out of range");

endmodule
